>>> rtl/wsh_pkg.sv
// ----------------------------------------------------------------------------
// wsh_pkg: shared types and constants
// Field widths, slot count, sequencer states and the cell control bundle for
// the weighted sum-of-squares row hash.
// ----------------------------------------------------------------------------
`default_nettype none

package wsh_pkg;

   localparam int KEY_FIELD_W    = 64;
   localparam int COUNT_W        = 5;
   localparam int INDEX_W        = 4;
   localparam int HASH_W         = 30;
   localparam int ROW_BITS_W     = 5;
   localparam int ACC_W          = 32;

   localparam int SLOT_COUNT     = 16;
   localparam int SLOT_IDX_W     = $clog2(SLOT_COUNT);

   localparam int MAX_WEIGHT_DEF = 16;
   localparam int KEY_BITS_DEF   = 64;

   localparam logic [ROW_BITS_W-1:0] ROW_BITS_RESET = ROW_BITS_W'(8);
   localparam logic [ROW_BITS_W-1:0] ROW_BITS_MIN   = ROW_BITS_W'(1);
   localparam logic [ROW_BITS_W-1:0] ROW_BITS_MAX   = ROW_BITS_W'(HASH_W);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIGIT,
      ST_DRAIN,
      ST_REDUCE,
      ST_OUTPUT,
      ST_ERROR
   } wsh_state_type;

   // Broadcast from the sequencer to every cell.
   typedef struct packed {
      logic              init;
      logic              red_load;
      logic              red_step;
      logic              shift;
      logic [HASH_W-1:0] mask;
   } cell_ctl_type;

endpackage

`default_nettype wire

>>> rtl/wsh_req_if.sv
// ----------------------------------------------------------------------------
// wsh_req_if: request channel
// Valid/ready channel carrying a server key and a replica count.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsh_req_if import wsh_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [KEY_FIELD_W-1:0] server_key;
   logic [COUNT_W-1:0]     replica_count;

   modport source (output valid, output server_key, output replica_count, input ready);
   modport sink   (input valid, input server_key, input replica_count, output ready);
endinterface

`default_nettype wire

>>> rtl/wsh_rsp_if.sv
// ----------------------------------------------------------------------------
// wsh_rsp_if: response channel
// Valid/ready channel carrying one row hash per replica.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsh_rsp_if import wsh_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] replica_index;
   logic [HASH_W-1:0]  row_hash;
   logic               bad_weight;
   logic               last;

   modport source (output valid, output replica_index, output row_hash,
                   output bad_weight, output last, input ready);
   modport sink   (input valid, input replica_index, input row_hash,
                   input bad_weight, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/wsh_cell.sv
// ----------------------------------------------------------------------------
// wsh_cell: accumulator cell
// Holds one accumulator. Applies acc + |acc*acc + digit| per digit, the square
// registered first; forwards the digit to the next cell, reduces |acc| modulo
// the mask one bit per cycle and shifts its row hash toward the chain head.
// ----------------------------------------------------------------------------
`default_nettype none

module wsh_cell import wsh_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cell_ctl_type          ctl,
   input  wire logic [SLOT_IDX_W-1:0] slot_id,
   input  wire logic                  in_valid,
   input  wire logic [HASH_W-1:0]     in_digit,
   output logic                       out_valid,
   output logic [HASH_W-1:0]          out_digit,
   input  wire logic [HASH_W-1:0]     next_hash,
   output logic [HASH_W-1:0]          hash
);

   logic              fwd_valid_ff;
   logic [HASH_W-1:0] fwd_digit_ff;
   logic              upd_ff;
   logic [ACC_W-1:0]  prod_ff;
   logic [ACC_W-1:0]  prod_in;
   logic [HASH_W-1:0] dig_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [ACC_W-1:0]  acc_in;
   logic [HASH_W-1:0] rem_ff;
   logic [HASH_W-1:0] rem_in;
   logic [HASH_W:0]   trial;
   logic [ACC_W-1:0]  sq_sum;

   function automatic logic [ACC_W-1:0] mag32(input logic [ACC_W-1:0] v);
      return v[ACC_W-1] ? (ACC_W'(0) - v) : v;
   endfunction

   assign prod_in = acc_ff * acc_ff;
   assign sq_sum  = prod_ff + ACC_W'(dig_ff);
   assign trial   = {rem_ff, acc_ff[ACC_W-1]};

   always_comb begin
      acc_in = acc_ff;
      if (ctl.init) begin
         acc_in = ACC_W'(slot_id);
      end else if (upd_ff) begin
         acc_in = acc_ff + mag32(sq_sum);
      end else if (ctl.red_load) begin
         acc_in = mag32(acc_ff);
      end else if (ctl.red_step) begin
         acc_in = {acc_ff[ACC_W-2:0], 1'b0};
      end
   end

   // One restoring step: bring in the next magnitude bit, drop the mask if it fits.
   always_comb begin
      rem_in = rem_ff;
      if (ctl.red_load) begin
         rem_in = '0;
      end else if (ctl.red_step) begin
         if (trial >= {1'b0, ctl.mask}) begin
            rem_in = HASH_W'(trial - {1'b0, ctl.mask});
         end else begin
            rem_in = HASH_W'(trial);
         end
      end else if (ctl.shift) begin
         rem_in = next_hash;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
         upd_ff       <= 1'b0;
      end else begin
         fwd_valid_ff <= in_valid;
         upd_ff       <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      fwd_digit_ff <= in_digit;
      if (in_valid) begin
         prod_ff <= prod_in;
         dig_ff  <= in_digit;
      end
      acc_ff <= acc_in;
      rem_ff <= rem_in;
   end

   assign out_valid = fwd_valid_ff;
   assign out_digit = fwd_digit_ff;
   assign hash      = rem_ff;

endmodule

`default_nettype wire

>>> rtl/wsh_ctrl.sv
// ----------------------------------------------------------------------------
// wsh_ctrl: sequencer and digit unit
// Folds the key into its residue modulo the mask, then for each base
// 2^row_bits digit, lowest first, issues the key's residue from that digit up
// at the chain head. Steps cells through drain, reduction and result unload.
// ----------------------------------------------------------------------------
`default_nettype none

module wsh_ctrl import wsh_pkg::*; #(
   parameter int MAX_WEIGHT = MAX_WEIGHT_DEF,
   parameter int KEY_BITS   = KEY_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [ROW_BITS_W-1:0] row_bits,
   wsh_req_if.sink                    req,
   wsh_rsp_if.source                  rsp,
   input  wire logic [HASH_W-1:0]     head_hash,
   output cell_ctl_type               ctl,
   output logic                       dig_valid,
   output logic [HASH_W-1:0]          dig_value
);

   localparam int WEIGHT_LIMIT = (MAX_WEIGHT > SLOT_COUNT) ? SLOT_COUNT : MAX_WEIGHT;
   localparam int CNT_W        = $clog2(ACC_W) + 1;
   localparam logic [CNT_W-1:0] DRAIN_LAST  = CNT_W'(SLOT_COUNT + 1);
   localparam logic [CNT_W-1:0] REDUCE_LAST = CNT_W'(ACC_W - 1);

   wsh_state_type          state_ff, state_in;
   logic [KEY_BITS-1:0]    scan_ff, scan_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [HASH_W-1:0]      sum_ff, sum_in;
   logic [COUNT_W-1:0]     weight_ff, weight_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   phase_ff, phase_in;

   logic [ROW_BITS_W-1:0]  shift;
   logic [HASH_W-1:0]      mask;
   logic                   weight_bad;
   logic                   out_last;
   logic                   issue;
   logic [KEY_BITS-1:0]    req_key;

   function automatic logic [HASH_W-1:0] add_mod(input logic [HASH_W-1:0] a,
                                                 input logic [HASH_W-1:0] c,
                                                 input logic [HASH_W-1:0] m);
      logic [HASH_W:0] s;
      s = {1'b0, a} + {1'b0, c};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return HASH_W'(s);
   endfunction

   function automatic logic [HASH_W-1:0] sub_mod(input logic [HASH_W-1:0] a,
                                                 input logic [HASH_W-1:0] c,
                                                 input logic [HASH_W-1:0] m);
      logic [HASH_W-1:0] cr;
      logic [HASH_W:0]   d;
      cr = (c == m) ? '0 : c;
      d  = {1'b0, a} - {1'b0, cr};
      if (d[HASH_W]) begin
         d = d + {1'b0, m};
      end
      return HASH_W'(d);
   endfunction

   always_comb begin
      shift = row_bits;
      if (row_bits < ROW_BITS_MIN) begin
         shift = ROW_BITS_MIN;
      end else if (row_bits > ROW_BITS_MAX) begin
         shift = ROW_BITS_MAX;
      end
   end

   assign mask       = HASH_W'(((HASH_W + 1)'(1) << shift) - (HASH_W + 1)'(1));
   assign req_key    = req.server_key[KEY_BITS-1:0];
   assign weight_bad = (req.replica_count == '0) ||
                       (req.replica_count > COUNT_W'(WEIGHT_LIMIT));
   assign out_last   = ((count_ff + CNT_W'(1)) == CNT_W'(weight_ff));
   assign issue      = (state_ff == ST_DIGIT) && !phase_ff && (key_ff != '0);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               state_in = weight_bad ? ST_ERROR : ST_SUM;
            end
         end
         ST_SUM: begin
            if (scan_ff == '0) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (key_ff == '0) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (count_ff == DRAIN_LAST) begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (count_ff == REDUCE_LAST) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (rsp.ready && out_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_ERROR: begin
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req.ready         = (state_ff == ST_IDLE);
      rsp.valid         = (state_ff == ST_OUTPUT) || (state_ff == ST_ERROR);
      rsp.bad_weight    = (state_ff == ST_ERROR);
      rsp.replica_index = (state_ff == ST_ERROR) ? '0 : count_ff[INDEX_W-1:0];
      rsp.row_hash      = (state_ff == ST_ERROR) ? '0 : head_hash;
      rsp.last          = (state_ff == ST_ERROR) || out_last;
      ctl.init          = (state_ff == ST_IDLE) && req.valid && !weight_bad;
      ctl.red_load      = (state_ff == ST_DRAIN) && (count_ff == DRAIN_LAST);
      ctl.red_step      = (state_ff == ST_REDUCE);
      ctl.shift         = (state_ff == ST_OUTPUT) && rsp.ready;
      ctl.mask          = mask;
      dig_valid         = issue;
      dig_value         = sum_ff;
   end

   // Datapath
   always_comb begin
      scan_in   = scan_ff;
      key_in    = key_ff;
      sum_in    = sum_ff;
      weight_in = weight_ff;
      count_in  = '0;
      phase_in  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            key_in    = req_key;
            scan_in   = req_key;
            sum_in    = '0;
            weight_in = req.replica_count;
         end
         ST_SUM: begin
            if (scan_ff != '0) begin
               sum_in  = add_mod(sum_ff, HASH_W'(scan_ff) & mask, mask);
               scan_in = scan_ff >> shift;
            end
         end
         ST_DIGIT: begin
            phase_in = !phase_ff;
            if (issue) begin
               // residue of the key above this digit
               sum_in = sub_mod(sum_ff, HASH_W'(key_ff) & mask, mask);
               key_in = key_ff >> shift;
            end
         end
         ST_DRAIN: begin
            count_in = (count_ff == DRAIN_LAST) ? '0 : count_ff + CNT_W'(1);
         end
         ST_REDUCE: begin
            count_in = (count_ff == REDUCE_LAST) ? '0 : count_ff + CNT_W'(1);
         end
         ST_OUTPUT: begin
            count_in = rsp.ready ? count_ff + CNT_W'(1) : count_ff;
         end
         default: begin
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff   <= scan_in;
      key_ff    <= key_in;
      sum_ff    <= sum_in;
      weight_ff <= weight_in;
   end

endmodule

`default_nettype wire

>>> rtl/weighted_sum_of_squares_hash.sv
// A key has 0..64 row_bits digits, none for a zero key. Results are offered one per
// cycle while rsp.ready is high. The next request is taken the cycle after the last
// result goes, and none is taken before. The time per request is set by the
// multiply/update per digit and the 32-step remainder; a bad weight answers in the
// next cycle. Reset is synchronous: row_bits returns to 8, accumulators stay.
// ----------------------------------------------------------------------------
// weighted_sum_of_squares_hash: row hash per replica
// Sequencer feeding a chain of sixteen accumulator cells; digits ripple down
// the chain and results shift back to the head.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_sum_of_squares_hash import wsh_pkg::*; #(
   parameter int MAX_WEIGHT = MAX_WEIGHT_DEF,
   parameter int KEY_BITS   = KEY_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   wsh_req_if.sink                    req,
   wsh_rsp_if.source                  rsp,
   input  wire logic                  csr_write_enable,
   input  wire logic [ROW_BITS_W-1:0] csr_write_data
);

   logic [ROW_BITS_W-1:0] row_bits_ff;
   cell_ctl_type          ctl;
   logic                  dig_valid_w [SLOT_COUNT];
   logic [HASH_W-1:0]     dig_value_w [SLOT_COUNT];
   logic [HASH_W-1:0]     hash_w      [SLOT_COUNT+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         row_bits_ff <= ROW_BITS_RESET;
      end else if (csr_write_enable) begin
         row_bits_ff <= csr_write_data;
      end
   end

   wsh_ctrl #(
      .MAX_WEIGHT (MAX_WEIGHT),
      .KEY_BITS   (KEY_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .row_bits  (row_bits_ff),
      .req       (req),
      .rsp       (rsp),
      .head_hash (hash_w[0]),
      .ctl       (ctl),
      .dig_valid (dig_valid_w[0]),
      .dig_value (dig_value_w[0])
   );

   // Tail of the chain shifts in zero.
   assign hash_w[SLOT_COUNT] = '0;

   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
      if (i < SLOT_COUNT - 1) begin : g_mid
         wsh_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .slot_id   (SLOT_IDX_W'(i)),
            .in_valid  (dig_valid_w[i]),
            .in_digit  (dig_value_w[i]),
            .out_valid (dig_valid_w[i+1]),
            .out_digit (dig_value_w[i+1]),
            .next_hash (hash_w[i+1]),
            .hash      (hash_w[i])
         );
      end else begin : g_tail
         wsh_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .slot_id   (SLOT_IDX_W'(i)),
            .in_valid  (dig_valid_w[i]),
            .in_digit  (dig_value_w[i]),
            .out_valid (),
            .out_digit (),
            .next_hash (hash_w[i+1]),
            .hash      (hash_w[i])
         );
      end
   end

endmodule

`default_nettype wire
